/* src/sprc_pkg.sv */
package sprc_pkg;

  // Motion state of the channel, also shown on the result word
  typedef enum logic [2:0] {
    ModeIdle    = 3'd0,
    ModeGoto    = 3'd1,
    ModeOpening = 3'd2,
    ModeHolding = 3'd3,
    ModeClosing = 3'd4
  } mode_e;

  // Input word action codes
  typedef enum logic [2:0] {
    ActTick     = 3'd0,
    ActGoto     = 3'd1,
    ActUnlatch  = 3'd2,
    ActPowerOff = 3'd3,
    ActPowerOn  = 3'd4
  } action_e;

  // Configuration register indexes
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CfgSafeMin    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgSafeMax    = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgRampStep   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgRampPeriod = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgHoldTicks  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgOpen       = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgClosed     = 3'd6;

  // Fixed values
  localparam logic [11:0] FarThresholdUs  = 12'd100;
  localparam logic [11:0] StartPositionUs = 12'd1500;
  localparam logic [11:0] ResetTargetUs   = 12'd1100;

  // Configuration reset values
  localparam logic [11:0] RstSafeMin    = 12'd600;
  localparam logic [11:0] RstSafeMax    = 12'd2400;
  localparam logic [7:0]  RstRampStep   = 8'd8;
  localparam logic [15:0] RstRampPeriod = 16'd4;
  localparam logic [15:0] RstHoldTicks  = 16'd400;
  localparam logic [11:0] RstOpen       = 12'd1900;
  localparam logic [11:0] RstClosed     = 12'd1100;

  typedef struct packed {
    logic [11:0] safe_min;
    logic [11:0] safe_max;
    logic [7:0]  ramp_step;
    logic [15:0] ramp_period;
    logic [15:0] hold_ticks;
    logic [11:0] open_us;
    logic [11:0] closed_us;
  } cfg_t;

  typedef struct packed {
    mode_e       mode;
    logic [11:0] position;
    logic [11:0] target;
    logic [15:0] ramp_wait;
    logic [15:0] hold_left;
    logic        powered;
  } state_t;

  // Clamp a signed width to [lo, hi]; on overlap x below lo gives lo, else hi
  function automatic logic [11:0] clamp_safe(logic signed [13:0] x,
                                             logic [11:0] lo, logic [11:0] hi);
    logic [11:0] res;
    if (x < $signed({2'b00, lo})) begin
      res = lo;
    end else if (x > $signed({2'b00, hi})) begin
      res = hi;
    end else begin
      res = x[11:0];
    end
    return res;
  endfunction

endpackage

/* src/sprc_step.sv */
module sprc_step import sprc_pkg::*; (
  input  state_t      state_i,
  input  cfg_t        cfg_i,
  input  logic [2:0]  action_i,
  input  logic [11:0] target_us_i,
  output state_t      state_o,
  output logic        written_o
);

  logic signed [13:0] pos_s, tgt_s, diff_s, abs_s;
  logic [11:0]        diff_abs;
  logic               near, far;
  logic [8:0]         step_sel;
  logic signed [13:0] goto_up, goto_dn, step_up, step_dn;
  logic [15:0]        next_wait, hold_dec;

  // Distance to target and step selection
  assign pos_s    = $signed({2'b00, state_i.position});
  assign tgt_s    = $signed({2'b00, state_i.target});
  assign diff_s   = tgt_s - pos_s;
  assign abs_s    = diff_s[13] ? -diff_s : diff_s;
  assign diff_abs = abs_s[11:0];
  assign near     = diff_abs <= {4'b0000, cfg_i.ramp_step};
  assign far      = diff_abs > FarThresholdUs;
  assign step_sel = far ? {cfg_i.ramp_step, 1'b0} : {1'b0, cfg_i.ramp_step};

  assign goto_up = pos_s + $signed({5'b00000, step_sel});
  assign goto_dn = pos_s - $signed({5'b00000, step_sel});
  assign step_up = pos_s + $signed({6'b000000, cfg_i.ramp_step});
  assign step_dn = pos_s - $signed({6'b000000, cfg_i.ramp_step});

  // Reload of the pacing counter; a zero period acts as one
  assign next_wait = (cfg_i.ramp_period == 16'd0) ? 16'd0 : cfg_i.ramp_period - 16'd1;

  // Hold countdown runs on every tick while holding
  assign hold_dec = (state_i.mode == ModeHolding && state_i.hold_left != 16'd0) ?
                    state_i.hold_left - 16'd1 : state_i.hold_left;

  // Apply one word to the state
  always_comb begin
    state_o   = state_i;
    written_o = 1'b0;
    unique case (action_i)
      ActTick: begin
        state_o.hold_left = hold_dec;
        if (state_i.ramp_wait != 16'd0) begin
          state_o.ramp_wait = state_i.ramp_wait - 16'd1;
        end else begin
          unique case (state_i.mode)
            ModeGoto: begin
              written_o = 1'b1;
              if (near) begin
                state_o.position = clamp_safe(tgt_s, cfg_i.safe_min, cfg_i.safe_max);
                state_o.mode     = ModeIdle;
              end else begin
                state_o.position = clamp_safe((state_i.target > state_i.position) ?
                                              goto_up : goto_dn,
                                              cfg_i.safe_min, cfg_i.safe_max);
                state_o.ramp_wait = next_wait;
              end
            end
            ModeOpening: begin
              if (state_i.position >= state_i.target) begin
                state_o.mode      = ModeHolding;
                state_o.hold_left = cfg_i.hold_ticks;
              end else begin
                state_o.position  = clamp_safe(step_up, cfg_i.safe_min, cfg_i.safe_max);
                state_o.ramp_wait = next_wait;
                written_o         = 1'b1;
              end
            end
            ModeHolding: begin
              if (hold_dec == 16'd0) begin
                state_o.mode   = ModeClosing;
                state_o.target = cfg_i.closed_us;
              end
              state_o.ramp_wait = next_wait;
            end
            ModeClosing: begin
              if (state_i.position <= state_i.target) begin
                state_o.mode = ModeIdle;
              end else begin
                state_o.position  = clamp_safe(step_dn, cfg_i.safe_min, cfg_i.safe_max);
                state_o.ramp_wait = next_wait;
                written_o         = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ActGoto: begin
        state_o.target    = clamp_safe($signed({2'b00, target_us_i}),
                                       cfg_i.safe_min, cfg_i.safe_max);
        state_o.mode      = ModeGoto;
        state_o.ramp_wait = 16'd0;
      end
      ActUnlatch: begin
        state_o.mode      = ModeOpening;
        state_o.target    = cfg_i.open_us;
        state_o.ramp_wait = 16'd0;
      end
      ActPowerOff: begin
        state_o.powered = 1'b0;
        state_o.mode    = ModeIdle;
      end
      ActPowerOn: begin
        state_o.powered  = 1'b1;
        state_o.position = clamp_safe(pos_s, cfg_i.safe_min, cfg_i.safe_max);
        written_o        = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

/* src/servo_pulse_ramp_controller.sv */
// Each word goes from the input register into the result register as its result.
// Throughput: one word per cycle; the input register and the result register
// each take a new word whenever the result register is empty or being taken.
// Reset: configuration returns to its defaults, width 1500 us, idle, powered,
// and both register stages empty.
module servo_pulse_ramp_controller import sprc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          action_i,
  input  logic [11:0]         target_us_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [11:0]         pulse_us_o,
  output logic [2:0]          motion_state_o,
  output logic                drive_enabled_o,
  output logic                pulse_written_o
);

  cfg_t        cfg_q;
  state_t      state_q, state_d;
  logic        in_valid_q, out_valid_q;
  logic [2:0]  action_q;
  logic [11:0] target_q;
  logic        written_d;
  logic        out_written_q, out_drive_q;
  logic [11:0] out_pulse_q;
  logic [2:0]  out_mode_q;
  logic        advance, in_load, proc;

  // Handshake control
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_load    = !in_valid_q || advance;
  assign proc       = in_valid_q && advance;
  assign in_stall_o = !in_load;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.safe_min    <= RstSafeMin;
      cfg_q.safe_max    <= RstSafeMax;
      cfg_q.ramp_step   <= RstRampStep;
      cfg_q.ramp_period <= RstRampPeriod;
      cfg_q.hold_ticks  <= RstHoldTicks;
      cfg_q.open_us     <= RstOpen;
      cfg_q.closed_us   <= RstClosed;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgSafeMin:    cfg_q.safe_min    <= cfg_wdata_i[11:0];
        CfgSafeMax:    cfg_q.safe_max    <= cfg_wdata_i[11:0];
        CfgRampStep:   cfg_q.ramp_step   <= cfg_wdata_i[7:0];
        CfgRampPeriod: cfg_q.ramp_period <= cfg_wdata_i[15:0];
        CfgHoldTicks:  cfg_q.hold_ticks  <= cfg_wdata_i[15:0];
        CfgOpen:       cfg_q.open_us     <= cfg_wdata_i[11:0];
        CfgClosed:     cfg_q.closed_us   <= cfg_wdata_i[11:0];
        default: begin
        end
      endcase
    end
  end

  // Input register: load a new word whenever the stage moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_load) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load && in_valid_i) begin
      action_q <= action_i;
      target_q <= target_us_i;
    end
  end

  sprc_step u_step (
    .state_i     (state_q),
    .cfg_i       (cfg_q),
    .action_i    (action_q),
    .target_us_i (target_q),
    .state_o     (state_d),
    .written_o   (written_d)
  );

  // Channel state: advance once per processed word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode      <= ModeIdle;
      state_q.position  <= StartPositionUs;
      state_q.target    <= ResetTargetUs;
      state_q.ramp_wait <= 16'd0;
      state_q.hold_left <= 16'd0;
      state_q.powered   <= 1'b1;
    end else if (proc) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      out_pulse_q   <= state_d.position;
      out_mode_q    <= state_d.mode;
      out_drive_q   <= state_d.powered;
      out_written_q <= written_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pulse_us_o      = out_pulse_q;
  assign motion_state_o  = out_mode_q;
  assign drive_enabled_o = out_drive_q;
  assign pulse_written_o = out_written_q;

  // The input stage stalls only behind a held result word
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_q && out_stall_i))
    else $error("input stalled without a held result");

  // Power off always leaves the channel idle and undriven
  a_power_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && action_q == ActPowerOff) |=> (state_q.mode == ModeIdle && !state_q.powered))
    else $error("power off did not idle the channel");

  // Unused action codes leave the state untouched and write nothing
  a_unused_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && (action_q == 3'd5 || action_q == 3'd6 || action_q == 3'd7))
    |=> ($stable(state_q) && !out_written_q))
    else $error("unused action code changed state");

  // A written width lies inside a consistent safe range
  a_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && written_d && cfg_q.safe_min <= cfg_q.safe_max && !cfg_we_i)
    |=> (state_q.position >= cfg_q.safe_min && state_q.position <= cfg_q.safe_max))
    else $error("written width outside safe range");

endmodule
